[sv/iate_pkg.sv]
// Shared types and constants for the indexed array table engine.
// Holds the beat structs, the operation and status codes, and the table sizes.
`timescale 1ns / 1ps

package iate_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW    = $clog2(CAPACITY);
  localparam int unsigned WordW    = 32;

  typedef enum logic [2:0] {
    FN_LOAD   = 3'd0,
    FN_READ   = 3'd1,
    FN_SEARCH = 3'd2,
    FN_UPDATE = 3'd3,
    FN_DELETE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_LIMIT    = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]               func;
    logic                     start_new;
    logic [7:0]               position;
    logic signed [WordW-1:0]  data_word;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [7:0]               found_position;
    logic signed [WordW-1:0]  read_word;
    logic [7:0]               entry_count;
  } out_beat_t;

endpackage

[sv/indexed_array_table_engine.sv]
// Top level of the indexed array table engine: sequencer, table RAM, output register.
// Depends on iate_pkg, iate_ram and iate_ctrl.
//
//   beat     | direction | handshake               | payload
//   input    | in        | in_valid_i / in_ready_o | in_i  (in_beat_t)
//   result   | out       | out_valid_o/ out_ready_i| out_o (out_beat_t)
//
// Load, update, errors, unused codes: accept goes straight to the result register; read goes via S_READ.
// Search: walks the entries from the first until a hit, or a miss after all live entries (up to CAPACITY).
// Delete: shifts each word after the position down by one, one RAM read and write per shifted word.
// Walks use the single RAM read port.
// Reset clears the live count and control; table contents are undefined until loaded.
// A stalled output holds its beat; the next input beat is taken once the result moves on.
`timescale 1ns / 1ps

module indexed_array_table_engine import iate_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_o
);

  logic             res_valid;
  logic             res_ready;
  out_beat_t        res;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [WordW-1:0] ram_rdata;
  logic             out_valid_q;
  out_beat_t        out_q;

  iate_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  iate_ram #(
    .Depth (CAPACITY),
    .Width (WordW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_ram_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("table RAM read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_o.entry_count) <= 32'(CAPACITY))
    else $error("entry count beyond capacity");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.found_position != 8'd0 |-> out_o.status == ST_OK)
    else $error("found position reported with a failing status");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("sequencer dropped a pending result");

endmodule

[sv/iate_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module iate_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/iate_ctrl.sv]
// Operation sequencer for the table engine: decode, checks, search and delete walks.
// Depends on iate_pkg; drives the table RAM and hands one result per input beat.
`timescale 1ns / 1ps

module iate_ctrl import iate_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_beat_t         in_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output out_beat_t        res_o,
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [WordW-1:0] ram_wdata_o,
  output logic             ram_re_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [WordW-1:0] ram_rdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [WordW-1:0] word_q, word_d;
  out_beat_t        res_q, res_d;
  logic [CntW-1:0]  base;
  logic [CntW-1:0]  idx_next;
  logic             pos_ok;

  assign pos_ok   = (32'(in_i.position) >= 32'd1) && (32'(in_i.position) <= 32'(count_q));
  assign base     = in_i.start_new ? '0 : count_q;
  assign idx_next = CntW'(idx_q) + CntW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    word_d      = word_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          word_d  = in_i.data_word;
          res_d   = '0;
          state_d = S_EMIT;
          unique case (in_i.func)
            FN_LOAD: begin
              if (32'(base) >= 32'(CAPACITY)) begin
                count_d      = '0;
                res_d.status = ST_LIMIT;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = AddrW'(base);
                ram_wdata_o = in_i.data_word;
                count_d     = base + CntW'(1);
              end
            end
            FN_READ: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
              end else if (!pos_ok) begin
                res_d.status = ST_BADPOS;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = AddrW'(in_i.position - 8'd1);
                state_d     = S_READ;
              end
            end
            FN_SEARCH: begin
              if (count_q == '0) begin
                res_d.status = ST_NOTFOUND;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = '0;
                idx_d       = '0;
                state_d     = S_SRCH;
              end
            end
            FN_UPDATE: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
              end else if (!pos_ok) begin
                res_d.status = ST_BADPOS;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = AddrW'(in_i.position - 8'd1);
                ram_wdata_o = in_i.data_word;
              end
            end
            FN_DELETE: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
              end else if (!pos_ok) begin
                res_d.status = ST_BADPOS;
              end else if (32'(in_i.position) == 32'(count_q)) begin
                count_d = count_q - CntW'(1);
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = AddrW'(in_i.position);
                idx_d       = AddrW'(in_i.position);
                state_d     = S_DEL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_d.read_word = ram_rdata_i;
        state_d         = S_EMIT;
      end
      S_SRCH: begin
        if (ram_rdata_i == word_q) begin
          res_d.found_position = 8'(idx_next);
          res_d.status         = ST_OK;
          state_d              = S_EMIT;
        end else if (idx_next >= count_q) begin
          res_d.status = ST_NOTFOUND;
          state_d      = S_EMIT;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = AddrW'(idx_next);
          idx_d       = AddrW'(idx_next);
        end
      end
      S_DEL: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q - AddrW'(1);
        ram_wdata_o = ram_rdata_i;
        if (idx_next < count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = AddrW'(idx_next);
          idx_d       = AddrW'(idx_next);
        end else begin
          count_d = count_q - CntW'(1);
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    word_q <= word_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);

  always_comb begin
    res_o             = res_q;
    res_o.entry_count = 8'(count_q);
  end

endmodule
